// File: rtl/core/mhpq_pkg.sv
package mhpq_pkg;

   // Default store geometry.
   localparam int unsigned HEAP_DEPTH_DEF = 256;
   localparam int unsigned KEY_WIDTH_DEF  = 32;

   // Fixed field widths.
   localparam int unsigned OCC_W    = 9;
   localparam int unsigned LIMIT_W  = 9;
   localparam int unsigned STATUS_W = 2;

   // Limit register value after reset.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

   // Request kinds carried in the request tuser.
   localparam logic REQ_INSERT  = 1'b0;
   localparam logic REQ_EXTRACT = 1'b1;

   // Result status codes carried in the response tuser.
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_UP   = 5'b00010,
      S_PUT  = 5'b00100,
      S_EXT  = 5'b01000,
      S_DOWN = 5'b10000
   } state_type;

endpackage

// File: rtl/core/min_heap_priority_queue_unit.sv
// Binary min-heap priority queue of signed keys. Each request transfer either inserts the
// key in req_tdata or extracts the smallest key held, and each gives exactly one response
// transfer carrying the extracted key (zero otherwise), a status (done, full, empty) and
// the key count after the request. The keys live in one synchronous memory with a registered
// read; the sequencer walks the heap one level per clock, reading the parent (insert) or
// both children (extract) while writing the level it leaves. One request is in work at a
// time, and a finished response may wait in the output register while the next request is
// taken. The csr write port sets the most keys the heap may hold (saturated at HEAP_DEPTH);
// write it only while the block is idle.
module min_heap_priority_queue_unit #(
   parameter int unsigned HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEF,
   parameter int unsigned KEY_WIDTH  = mhpq_pkg::KEY_WIDTH_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   // Configuration write: heap limit.
   input  logic                                              csr_we,
   input  logic [mhpq_pkg::LIMIT_W-1:0]                      csr_wdata,
   // Request channel.
   input  logic                                              req_tvalid,
   output logic                                              req_tready,
   // tdata fields from bit 0: key_in.
   input  logic [((KEY_WIDTH+7)/8)*8-1:0]                    req_tdata,
   // tuser fields from bit 0: req_type.
   input  logic                                              req_tuser,
   // Response channel.
   output logic                                              rsp_tvalid,
   input  logic                                              rsp_tready,
   // tdata fields from bit 0: key_out, occupancy.
   output logic [((KEY_WIDTH+mhpq_pkg::OCC_W+7)/8)*8-1:0]    rsp_tdata,
   // tuser fields from bit 0: status.
   output logic [mhpq_pkg::STATUS_W-1:0]                     rsp_tuser
);
   import mhpq_pkg::*;

   localparam int unsigned ADDR_W      = $clog2(HEAP_DEPTH);
   localparam int unsigned CHILD_W     = OCC_W + 1;
   localparam int unsigned RSP_TDATA_W = ((KEY_WIDTH + OCC_W + 7) / 8) * 8;

   // Key store, one write and two read addresses, registered read data.
   logic [KEY_WIDTH-1:0] key_store [HEAP_DEPTH];
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_wa;
   logic [KEY_WIDTH-1:0] mem_wd;
   logic [ADDR_W-1:0]    mem_ra0;
   logic [ADDR_W-1:0]    mem_ra1;
   logic [KEY_WIDTH-1:0] rd0_ff;
   logic [KEY_WIDTH-1:0] rd1_ff;

   // Control and working registers.
   state_type            state_ff, state_in;
   logic [OCC_W-1:0]     count_ff, count_in;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [OCC_W-1:0]     pos_ff, pos_in;
   logic [KEY_WIDTH-1:0] cur_ff, cur_in;
   logic [KEY_WIDTH-1:0] res_key_ff, res_key_in;
   status_type           res_status_ff, res_status_in;
   logic                 res_pend_ff, res_pend_in;

   // Response output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KEY_WIDTH-1:0] rsp_key_ff;
   status_type           rsp_status_ff;
   logic [OCC_W-1:0]     rsp_occ_ff;
   logic                 rsp_load;

   // Datapath helpers.
   logic                 req_fire;
   logic                 heap_full;
   logic [OCC_W-1:0]     parent_idx;
   logic [OCC_W-1:0]     req_parent_idx;
   logic [CHILD_W-1:0]   left_idx;
   logic [CHILD_W-1:0]   right_idx;
   logic                 left_ok;
   logic                 right_ok;
   logic                 left_less;
   logic                 right_less;
   logic [KEY_WIDTH-1:0] best_val;
   logic [CHILD_W-1:0]   best_idx;
   logic [CHILD_W:0]     best_left;

   // Memory array and read registers.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_store[mem_wa] <= mem_wd;
      end
      rd0_ff <= key_store[mem_ra0];
      rd1_ff <= key_store[mem_ra1];
   end

   // A new request is taken only between requests and once a pending result has moved on; a response may still wait.
   assign req_tready = (state_ff == S_IDLE) && !res_pend_ff;
   assign req_fire   = req_tvalid && req_tready;

   // Full when the count reaches the limit or the store depth.
   assign heap_full = (count_ff >= limit_ff) || (32'(count_ff) >= 32'(HEAP_DEPTH));

   assign parent_idx     = (pos_ff - OCC_W'(1)) >> 1;
   assign req_parent_idx = (count_ff - OCC_W'(1)) >> 1;

   // Child selection for the sift-down step: left wins ties, compares are strict.
   assign left_idx   = {pos_ff, 1'b1};
   assign right_idx  = left_idx + CHILD_W'(1);
   assign left_ok    = left_idx < {1'b0, count_ff};
   assign right_ok   = right_idx < {1'b0, count_ff};
   assign left_less  = left_ok && ($signed(rd0_ff) < $signed(cur_ff));

   always_comb begin
      best_val = left_less ? rd0_ff : cur_ff;
      best_idx = left_idx;
      right_less = right_ok && ($signed(rd1_ff) < $signed(best_val));
      if (right_less) begin
         best_val = rd1_ff;
         best_idx = right_idx;
      end
   end

   assign best_left = {best_idx, 1'b1};

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      res_pend_in   = res_pend_ff;
      mem_we        = 1'b0;
      mem_wa        = ADDR_W'(pos_ff);
      mem_wd        = cur_ff;
      mem_ra0       = '0;
      mem_ra1       = '0;

      // Hand a finished result to the output register once it is free.
      if (rsp_load) begin
         res_pend_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_key_in    = '0;
               res_status_in = ST_DONE;
               if (req_tuser == REQ_INSERT) begin
                  if (heap_full) begin
                     res_status_in = ST_FULL;
                     res_pend_in   = 1'b1;
                  end else begin
                     count_in = count_ff + OCC_W'(1);
                     pos_in   = count_ff;
                     cur_in   = req_tdata[KEY_WIDTH-1:0];
                     if (count_ff == '0) begin
                        // First key goes straight to the root.
                        mem_we      = 1'b1;
                        mem_wa      = '0;
                        mem_wd      = req_tdata[KEY_WIDTH-1:0];
                        res_pend_in = 1'b1;
                     end else begin
                        mem_ra0  = ADDR_W'(req_parent_idx);
                        state_in = S_UP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     res_pend_in   = 1'b1;
                  end else begin
                     // Fetch the root and the last key together.
                     count_in = count_ff - OCC_W'(1);
                     mem_ra0  = '0;
                     mem_ra1  = ADDR_W'(count_ff - OCC_W'(1));
                     state_in = S_EXT;
                  end
               end
            end
         end

         S_UP: begin
            // Parent key is in rd0_ff.
            if ($signed(cur_ff) < $signed(rd0_ff)) begin
               mem_we  = 1'b1;
               mem_wd  = rd0_ff;
               pos_in  = parent_idx;
               mem_ra0 = ADDR_W'((parent_idx - OCC_W'(1)) >> 1);
               if (parent_idx == '0) begin
                  state_in = S_PUT;
               end
            end else begin
               mem_we      = 1'b1;
               res_pend_in = 1'b1;
               state_in    = S_IDLE;
            end
         end

         S_PUT: begin
            mem_we      = 1'b1;
            res_pend_in = 1'b1;
            state_in    = S_IDLE;
         end

         S_EXT: begin
            res_key_in = rd0_ff;
            cur_in     = rd1_ff;
            pos_in     = '0;
            if (count_ff == '0) begin
               res_pend_in = 1'b1;
               state_in    = S_IDLE;
            end else begin
               mem_ra0  = ADDR_W'(1);
               mem_ra1  = ADDR_W'(2);
               state_in = S_DOWN;
            end
         end

         S_DOWN: begin
            // Children keys are in rd0_ff and rd1_ff.
            mem_we = 1'b1;
            if (left_less || right_less) begin
               mem_wd  = best_val;
               pos_in  = OCC_W'(best_idx);
               mem_ra0 = ADDR_W'(best_left);
               mem_ra1 = ADDR_W'(best_left + (CHILD_W + 1)'(1));
            end else begin
               res_pend_in = 1'b1;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register loads when empty or when its transfer completes.
   assign rsp_load = res_pend_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         res_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         res_pend_ff  <= res_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_key_ff    <= res_key_ff;
         rsp_status_ff <= res_status_ff;
         rsp_occ_ff    <= count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_occ_ff, rsp_key_ff});
   assign rsp_tuser  = rsp_status_ff;

   // An extract on an empty heap reports empty without touching the store.
   a_empty_extract: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == REQ_EXTRACT) && (count_ff == '0)
      |=> res_pend_ff && (res_status_ff == ST_EMPTY) && (state_ff == S_IDLE))
      else $error("empty extract did not report empty");

   // The key count moves only when a request is taken.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("key count changed without a request");

   // The count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(HEAP_DEPTH))
      else $error("key count above store depth");

   // Sifting up never starts from the root.
   a_up_not_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP) |-> (pos_ff != '0))
      else $error("sift-up at the root");

   // A new request never arrives while a result is still waiting to be handed on.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !res_pend_ff)
      else $error("request taken over a pending result");

endmodule

// File: tb/min_heap_priority_queue_unit_tb.sv
`timescale 1ns / 100ps

module min_heap_priority_queue_unit_tb;
   import mhpq_pkg::*;

   localparam int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF;
   localparam int unsigned KEY_WIDTH  = KEY_WIDTH_DEF;
   localparam int unsigned REQ_W      = ((KEY_WIDTH + 7) / 8) * 8;
   localparam int unsigned RSP_W      = ((KEY_WIDTH + OCC_W + 7) / 8) * 8;

   // One response as the heap should produce it.
   typedef struct {
      logic [KEY_WIDTH-1:0] key;
      status_type           status;
      logic [OCC_W-1:0]     occupancy;
   } heap_result_type;

   // Tracks the heap contents and the limit, and holds the responses still owed by the block.
   class heap_tracker;
      logic signed [KEY_WIDTH-1:0] slots [HEAP_DEPTH];
      int unsigned                 occupancy;
      int unsigned                 limit_value;
      heap_result_type             owed_q [$];
      int unsigned                 errors;

      function new();
         occupancy   = 0;
         limit_value = LIMIT_RESET;
         errors      = 0;
      endfunction

      function void set_limit(input logic [LIMIT_W-1:0] value);
         limit_value = value;
      endfunction

      function int unsigned effective_limit();
         return (limit_value > HEAP_DEPTH) ? HEAP_DEPTH : limit_value;
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction

      function void swap_slots(input int unsigned a, input int unsigned b);
         logic signed [KEY_WIDTH-1:0] held;
         held     = slots[a];
         slots[a] = slots[b];
         slots[b] = held;
      endfunction

      // Applies one accepted request to the heap and queues the response it must give.
      function void note_request(input logic kind, input logic [KEY_WIDTH-1:0] key);
         heap_result_type res;
         int unsigned     pos;
         int unsigned     parent;
         int unsigned     best;
         int unsigned     left;
         int unsigned     right;
         res.key    = '0;
         res.status = ST_DONE;
         if (kind == REQ_INSERT) begin
            if (occupancy >= effective_limit()) begin
               res.status = ST_FULL;
            end else begin
               // Place the key at the end and let it rise past strictly greater parents.
               pos        = occupancy;
               slots[pos] = key;
               while (pos > 0) begin
                  parent = (pos - 1) / 2;
                  if (!(slots[pos] < slots[parent])) break;
                  swap_slots(pos, parent);
                  pos = parent;
               end
               occupancy++;
            end
         end else begin
            if (occupancy == 0) begin
               res.status = ST_EMPTY;
            end else begin
               // Take the root, move the last key up and let it sink; the left child wins ties.
               res.key   = slots[0];
               occupancy--;
               slots[0]  = slots[occupancy];
               pos       = 0;
               forever begin
                  best  = pos;
                  left  = 2 * pos + 1;
                  right = 2 * pos + 2;
                  if (left < occupancy && slots[left] < slots[best]) best = left;
                  if (right < occupancy && slots[right] < slots[best]) best = right;
                  if (best == pos) break;
                  swap_slots(pos, best);
                  pos = best;
               end
            end
         end
         res.occupancy = OCC_W'(occupancy);
         owed_q.push_back(res);
      endfunction

      // Compares one response transfer with the oldest owed response.
      function void check_response(input logic [KEY_WIDTH-1:0] key,
                                   input logic [STATUS_W-1:0] status,
                                   input logic [OCC_W-1:0] occ);
         heap_result_type want;
         if (owed_q.size() == 0) begin
            $error("Response with no request outstanding: key_out %0d, status %0d, occupancy %0d",
                   $signed(key), status, occ);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         if (key !== want.key) begin
            $error("key_out mismatch: expected %0d, actual %0d", $signed(want.key), $signed(key));
            errors++;
         end
         if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (occ !== want.occupancy) begin
            $error("occupancy mismatch: expected %0d, actual %0d", want.occupancy, occ);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we;
   logic [LIMIT_W-1:0] csr_wdata;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata;
   logic               req_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;

   heap_tracker heap_sb = new();
   int unsigned req_gap_max   = 13;
   int unsigned rsp_stall_max = 13;

   min_heap_priority_queue_unit #(
      .HEAP_DEPTH(HEAP_DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Picks how long a side may idle for the coming stretch; zero gives back-to-back transfers.
   function automatic int unsigned pick_idle_max();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 3;
         default: return 13;
      endcase
   endfunction

   // Mixes full-range keys, a narrow band that produces many equal keys, and the extremes.
   function automatic logic [KEY_WIDTH-1:0] pick_key();
      case ($urandom_range(0, 3))
         1: return $urandom_range(0, 8) - 4;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   // Drives one request after a random gap and waits for its transfer; entered at a falling edge.
   task automatic send_request(input logic kind, input logic [KEY_WIDTH-1:0] key);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      heap_sb.note_request(kind, key);
      @(negedge clock);
   endtask

   // Holds off new requests until every owed response has arrived and the block has settled.
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (heap_sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_heap_limit(input logic [LIMIT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      heap_sb.set_limit(value);
   endtask

   // Response side: random stalls before each transfer, then checking of what arrives.
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_stall_max = pick_idle_max();
         stall = $urandom_range(0, rsp_stall_max);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         heap_sb.check_response(rsp_tdata[KEY_WIDTH-1:0], rsp_tuser,
                                rsp_tdata[KEY_WIDTH+OCC_W-1:KEY_WIDTH]);
         @(negedge clock);
      end
   end

   // Request side: directed checks, then phases of fill and drain under several limits.
   initial begin
      int unsigned phase_limits [$];
      int unsigned lim_eff;
      int unsigned n_items;
      bit          filling;
      logic        kind;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_INSERT;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty extract, extreme and equal keys, then extracts in heap order.
      send_request(REQ_EXTRACT, 32'h1234_5678);
      send_request(REQ_INSERT, 32'h0000_0000);
      send_request(REQ_INSERT, 32'h7FFF_FFFF);
      send_request(REQ_INSERT, 32'h8000_0000);
      send_request(REQ_INSERT, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 32'h0000_0001);
      send_request(REQ_INSERT, 32'h0000_0005);
      send_request(REQ_INSERT, 32'h0000_0005);
      send_request(REQ_INSERT, -32'sd7);
      send_request(REQ_INSERT, 32'h0000_0005);
      repeat (4) send_request(REQ_EXTRACT, 32'hFFFF_FFFF);

      // Limit lowered below the count: inserts are refused until extracts bring the count under it.
      wait_until_drained();
      write_heap_limit(9'd2);
      send_request(REQ_INSERT, 32'h0000_0009);
      repeat (3) send_request(REQ_EXTRACT, 32'h0000_0000);
      send_request(REQ_INSERT, 32'h0000_0009);
      send_request(REQ_EXTRACT, 32'h0000_0000);
      send_request(REQ_INSERT, 32'hFFFF_FFF0);

      // A zero limit refuses every insert; the heap then drains to empty.
      wait_until_drained();
      write_heap_limit(9'd0);
      send_request(REQ_INSERT, 32'h0000_0003);
      repeat (3) send_request(REQ_EXTRACT, 32'h0000_0000);

      // Random phases sweep the count between empty and the limit, with a little noise.
      phase_limits = '{1, 511, 3, 256, 0, 17, $urandom_range(4, 300), 2, 256};
      foreach (phase_limits[p]) begin
         wait_until_drained();
         write_heap_limit(LIMIT_W'(phase_limits[p]));
         lim_eff     = heap_sb.effective_limit();
         n_items     = lim_eff * 3 / 2 + 45;
         filling     = 1'b1;
         req_gap_max = pick_idle_max();
         repeat (n_items) begin
            if ($urandom_range(0, 39) == 0) req_gap_max = pick_idle_max();
            if (filling && heap_sb.occupancy >= lim_eff && $urandom_range(0, 2) == 0)
               filling = 1'b0;
            else if (!filling && heap_sb.occupancy == 0 && $urandom_range(0, 2) == 0)
               filling = 1'b1;
            kind = filling ? REQ_INSERT : REQ_EXTRACT;
            if ($urandom_range(0, 19) == 0) kind = ~kind;
            send_request(kind, pick_key());
         end
      end

      wait_until_drained();
      repeat (20) @(negedge clock);
      if (heap_sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
